[rtl/hkcfe_pkg.sv]
// Shared types, codes and the result builder for the hotkey command frame engine.
// No dependencies; the core imports this package.
package hkcfe_pkg;

  // Input transfer payload
  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] key_type;
    logic [7:0] key_code;
    logic [3:0] status_code;
    logic [4:0] entry_index;
    logic       last;
  } out_item_t;

  // Input modes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Frame commands
  localparam logic [7:0] OP_SET  = 8'h01;
  localparam logic [7:0] OP_RUN  = 8'h02;
  localparam logic [7:0] OP_LIST = 8'h03;

  // Status codes
  localparam logic [3:0] ST_CSUM        = 4'd0;
  localparam logic [3:0] ST_UNKNOWN     = 4'd1;
  localparam logic [3:0] ST_SHORT       = 4'd2;
  localparam logic [3:0] ST_INDEX       = 4'd3;
  localparam logic [3:0] ST_TYPE        = 4'd4;
  localparam logic [3:0] ST_COUNT       = 4'd5;
  localparam logic [3:0] ST_DELAY       = 4'd6;
  localparam logic [3:0] ST_SET_OK      = 4'd7;
  localparam logic [3:0] ST_BUSY        = 4'd8;
  localparam logic [3:0] ST_STARTED     = 4'd9;
  localparam logic [3:0] ST_STORED_TYPE = 4'd10;
  localparam logic [3:0] ST_LIST        = 4'd11;

  // Reset value of the delay limit register
  localparam logic [15:0] MAX_DELAY_RST = 16'd5000;

  // Assemble one result word
  function automatic out_item_t mk_out(input logic [1:0] r_kind, input logic [1:0] r_typ,
                                       input logic [7:0] r_code, input logic [3:0] r_status,
                                       input logic [4:0] r_idx, input logic r_last);
    out_item_t o;
    o.kind        = r_kind;
    o.key_type    = r_typ;
    o.key_code    = r_code;
    o.status_code = r_status;
    o.entry_index = r_idx;
    o.last        = r_last;
    return o;
  endfunction

endpackage

[rtl/hkcfe_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hkcfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/hotkey_command_frame_engine_core.sv]
// Top level of the hotkey command frame engine: frame assembly, command execution, hold timer.
// Depends on hkcfe_pkg and hkcfe_ram (hotkey table storage).

// Each transfer is a received byte or a millisecond tick. Ticks and all bytes but a frame's
// checksum give at most one result. A checksum byte of a set, list, bad or unknown frame, or
// of a run frame rejected before the table, gives its status result directly. A run frame that
// reaches the table issues the table read with the checksum byte, then checks the stored entry
// and ends with a stored type status if its type is bad; else the press sequencer gives one
// result per cycle, n key presses (at most MAX_KEYS) and then the started status. busy is high
// while the entry is checked and the presses are sequenced. Results appear on out_item for one
// cycle with out_strobe and cannot be held off. The table is erased after reset through
// per-entry valid bits, so no clearing pass is needed.
module hotkey_command_frame_engine_core
  import hkcfe_pkg::*;
#(
  parameter int ENTRY_COUNT = 32,
  parameter int MAX_KEYS    = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int PD    = MAX_KEYS + 5;
  localparam int PD_W  = $clog2(PD);
  localparam int KC_W  = $clog2(MAX_KEYS + 1);
  localparam int CD_W  = 8 * MAX_KEYS;
  localparam int ENT_W = 32 + CD_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_KEYS = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [15:0]      max_delay_r;
  logic [8:0]       pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       pl_r [PD];
  logic             pl_we;
  logic [PD_W-1:0]  pl_waddr;
  logic             task_r, task_nxt;
  logic [7:0]       ttype_r, ttype_nxt;
  logic [15:0]      tdelay_r, tdelay_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [ENTRY_COUNT-1:0] vld_r;
  logic [CD_W-1:0]  codes_r, codes_nxt;
  logic [KC_W-1:0]  left_r, left_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             in_fire;
  logic [7:0]       b;
  logic [8:0]       pl_off;
  logic [7:0]       idx;
  logic             idx_ok;
  logic [7:0]       set_typ, set_cnt;
  logic [15:0]      set_delay;
  logic [CD_W-1:0]  set_codes;
  logic             ram_we;
  logic [ENT_W-1:0] ram_wdata, ram_rdata, ent;
  logic [7:0]       ent_cnt, ent_typ;
  logic [15:0]      elapsed_inc;

  assign in_fire = start && !busy;
  assign b       = in_item.byte_value;
  assign pl_off  = pos_r - 9'd2;
  assign idx     = pl_r[0];
  assign idx_ok  = {1'b0, idx} < 9'(ENTRY_COUNT);

  // Set frame fields
  assign set_typ   = pl_r[1];
  assign set_cnt   = pl_r[2];
  assign set_delay = {pl_r[3 + MAX_KEYS], pl_r[4 + MAX_KEYS]};
  always_comb begin
    for (int k = 0; k < MAX_KEYS; k++) begin
      set_codes[k*8 +: 8] = pl_r[3 + k];
    end
  end
  // Entry layout: delay, codes, type, count (count in the low byte)
  assign ram_wdata = {set_delay, set_codes, set_typ, set_cnt};

  // Erased entries read as all ones
  assign ent     = vld_r[idx[IDX_W-1:0]] ? ram_rdata : '1;
  assign ent_cnt = ent[7:0];
  assign ent_typ = ent[15:8];

  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  hkcfe_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRY_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Next-state logic for frame assembly, command execution and the timer
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    cmd_nxt        = cmd_r;
    sum_nxt        = sum_r;
    pl_we          = 1'b0;
    pl_waddr       = pl_off[PD_W-1:0];
    task_nxt       = task_r;
    ttype_nxt      = ttype_r;
    tdelay_nxt     = tdelay_r;
    elapsed_nxt    = elapsed_r;
    codes_nxt      = codes_r;
    left_nxt       = left_r;
    ram_we         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.mode == MODE_TICK) begin
            // Advance the hold timer, release when it reaches the delay
            if (task_r) begin
              elapsed_nxt = elapsed_inc;
              if (elapsed_inc >= tdelay_r) begin
                task_nxt       = 1'b0;
                out_strobe_nxt = 1'b1;
                out_item_nxt   = mk_out(KIND_RELEASE, ttype_r[1:0], 8'd0, 4'd0, 5'd0, 1'b1);
              end
            end
          end else if (pos_r == 9'd0) begin
            cmd_nxt = b;
            sum_nxt = b;
            pos_nxt = 9'd1;
          end else if (pos_r == 9'd1) begin
            len_nxt = b;
            sum_nxt = sum_r + b;
            pos_nxt = 9'd2;
          end else if (pos_r < {1'b0, len_r} + 9'd2) begin
            // Payload byte: keep the first PD, sum them all
            pl_we   = pl_off < 9'(PD);
            sum_nxt = sum_r + b;
            pos_nxt = pos_r + 9'd1;
          end else begin
            // Checksum byte: verify and dispatch
            pos_nxt        = 9'd0;
            out_strobe_nxt = 1'b1;
            out_item_nxt   = mk_out(KIND_STATUS, 2'd0, 8'd0, ST_CSUM, 5'd0, 1'b1);
            if (sum_r != b) begin
              out_item_nxt.status_code = ST_CSUM;
            end else if (cmd_r == OP_SET) begin
              priority if (len_r < 8'(PD)) begin
                out_item_nxt.status_code = ST_SHORT;
              end else if (!idx_ok) begin
                out_item_nxt.status_code = ST_INDEX;
              end else if (set_typ == 8'd0 || set_typ > 8'd3) begin
                out_item_nxt.status_code = ST_TYPE;
              end else if (set_cnt == 8'd0 || set_cnt > 8'(MAX_KEYS)) begin
                out_item_nxt.status_code = ST_COUNT;
              end else if (set_delay > max_delay_r) begin
                out_item_nxt.status_code = ST_DELAY;
              end else begin
                ram_we                   = 1'b1;
                out_item_nxt.status_code = ST_SET_OK;
                out_item_nxt.entry_index = idx[4:0];
              end
            end else if (cmd_r == OP_RUN) begin
              priority if (task_r) begin
                out_item_nxt.status_code = ST_BUSY;
              end else if (len_r == 8'd0) begin
                out_item_nxt.status_code = ST_SHORT;
              end else if (!idx_ok) begin
                out_item_nxt.status_code = ST_INDEX;
              end else begin
                // Table read issued this cycle, data next cycle
                out_strobe_nxt = 1'b0;
                state_nxt      = S_READ;
              end
            end else if (cmd_r == OP_LIST) begin
              out_item_nxt.status_code = ST_LIST;
            end else begin
              out_item_nxt.status_code = ST_UNKNOWN;
            end
          end
        end
      end
      S_READ: begin
        // Check the stored entry and start the task if its type is valid
        if (ent_typ == 8'd0 || ent_typ > 8'd3) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = mk_out(KIND_STATUS, 2'd0, 8'd0, ST_STORED_TYPE, 5'd0, 1'b1);
          state_nxt      = S_IDLE;
        end else begin
          task_nxt    = 1'b1;
          ttype_nxt   = ent_typ;
          tdelay_nxt  = ent[ENT_W-1 -: 16];
          elapsed_nxt = 16'd0;
          codes_nxt   = ent[16 +: CD_W];
          left_nxt    = (ent_cnt > 8'(MAX_KEYS)) ? KC_W'(MAX_KEYS) : ent_cnt[KC_W-1:0];
          state_nxt   = S_KEYS;
        end
      end
      S_KEYS: begin
        // One press per cycle, then the started status
        out_strobe_nxt = 1'b1;
        if (left_r != '0) begin
          out_item_nxt = mk_out(KIND_PRESS, ttype_r[1:0], codes_r[7:0], 4'd0, 5'd0, 1'b0);
          codes_nxt    = codes_r >> 8;
          left_nxt     = left_r - KC_W'(1);
        end else begin
          out_item_nxt = mk_out(KIND_STATUS, 2'd0, 8'd0, ST_STARTED, idx[4:0], 1'b1);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_delay_r  <= MAX_DELAY_RST;
      pos_r        <= '0;
      len_r        <= '0;
      cmd_r        <= '0;
      sum_r        <= '0;
      task_r       <= 1'b0;
      ttype_r      <= '0;
      tdelay_r     <= '0;
      elapsed_r    <= '0;
      vld_r        <= '0;
      left_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      cmd_r        <= cmd_nxt;
      sum_r        <= sum_nxt;
      task_r       <= task_nxt;
      ttype_r      <= ttype_nxt;
      tdelay_r     <= tdelay_nxt;
      elapsed_r    <= elapsed_nxt;
      left_r       <= left_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        max_delay_r <= cfg_wdata;
      end
      if (ram_we) begin
        vld_r[idx[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    codes_r    <= codes_nxt;
    out_item_r <= out_item_nxt;
    if (pl_we) begin
      pl_r[pl_waddr] <= b;
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  // Presses carry a real key type and no status
  a_press_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == KIND_PRESS |->
      out_item.key_type != 2'd0 && out_item.status_code == ST_CSUM && !out_item.last)
    else $error("press result with bad fields");

  // The press sequencer only runs with a task started
  a_keys_task: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KEYS |-> task_r)
    else $error("press sequencer without active task");

  // A release ends the task
  a_release_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == KIND_RELEASE |-> !task_r && $past(task_r))
    else $error("release without active task");

  // The started status leaves a task running
  a_started_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == KIND_STATUS && out_item.status_code == ST_STARTED
      |-> task_r && !busy)
    else $error("started status without task");
`endif

endmodule
